FILE: rtl/sdhp_pkg.sv
package sdhp_pkg;

    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int VALUE_W            = 64;
    localparam int CHAR_W             = 8;
    localparam int DIGIT_W            = 4;

    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;

    localparam logic [DIGIT_W-1:0] HEX_LETTER_BASE = 4'd10;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_BAD
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   negative;
        logic   hex_mode;
        logic   too_big;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:    PH_START,
        negative: 1'b0,
        hex_mode: 1'b0,
        too_big:  1'b0
    };

endpackage

FILE: rtl/sdhp_step.sv
module sdhp_step
    import sdhp_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  parse_state_t                  st,
    input  logic         [VALUE_BITS-2:0] mag,
    input  logic         [CHAR_W-1:0]     char_code,
    input  logic                          has_char,
    input  logic                          is_last,
    output parse_state_t                  st_next,
    output logic         [VALUE_BITS-2:0] mag_next,
    output logic                          emit,
    output logic                          parse_ok,
    output logic signed  [VALUE_W-1:0]    value
);

    localparam int ACC_W = VALUE_BITS + 3;
    localparam logic [ACC_W-1:0] LIM = {4'b0000, {(VALUE_BITS-1){1'b1}}};

    logic               is_dec;
    logic               is_lo_hex;
    logic               is_up_hex;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [ACC_W-1:0]   acc_ext;
    logic [ACC_W-1:0]   acc_prod;
    logic [ACC_W-1:0]   acc_sum;
    logic               acc_over;
    logic               take_digit;
    parse_state_t       st_upd;
    logic [VALUE_BITS-2:0] mag_upd;
    logic               ok_now;
    logic [VALUE_W-1:0] mag_wide;

    always_comb
    begin
        is_dec    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_lo_hex = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_F);
        is_up_hex = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_F);
        is_digit  = is_dec || (st.hex_mode && (is_lo_hex || is_up_hex));
        if (is_dec)
        begin
            digit = DIGIT_W'(char_code - CH_ZERO);
        end
        else if (is_lo_hex)
        begin
            digit = DIGIT_W'(char_code - CH_LOWER_A) + HEX_LETTER_BASE;
        end
        else
        begin
            digit = DIGIT_W'(char_code - CH_UPPER_A) + HEX_LETTER_BASE;
        end
    end

    // Overflow test: mag * base + digit must not pass the largest positive value.
    always_comb
    begin
        acc_ext  = {4'b0000, mag};
        acc_prod = st.hex_mode ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
        acc_sum  = acc_prod + ACC_W'(digit);
        acc_over = acc_sum > LIM;
    end

    always_comb
    begin
        st_upd     = st;
        mag_upd    = mag;
        take_digit = 1'b0;
        if (has_char)
        begin
            unique case (st.phase)
                PH_START,
                PH_SIGNED:
                begin
                    if ((st.phase == PH_START) &&
                        ((char_code == CH_MINUS) || (char_code == CH_PLUS)))
                    begin
                        st_upd.negative = (char_code == CH_MINUS);
                        st_upd.phase    = PH_SIGNED;
                    end
                    else if (char_code == CH_ZERO)
                    begin
                        st_upd.phase = PH_ZERO;
                    end
                    else if (is_digit)
                    begin
                        take_digit   = 1'b1;
                        st_upd.phase = PH_DIGITS;
                    end
                    else
                    begin
                        st_upd.phase = PH_BAD;
                    end
                end
                PH_ZERO:
                begin
                    if ((char_code == CH_LOWER_X) || (char_code == CH_UPPER_X))
                    begin
                        st_upd.hex_mode = 1'b1;
                        st_upd.phase    = PH_PREFIX;
                    end
                    else if (is_digit)
                    begin
                        take_digit   = 1'b1;
                        st_upd.phase = PH_DIGITS;
                    end
                    else
                    begin
                        st_upd.phase = PH_BAD;
                    end
                end
                PH_PREFIX,
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        take_digit   = 1'b1;
                        st_upd.phase = PH_DIGITS;
                    end
                    else
                    begin
                        st_upd.phase = PH_BAD;
                    end
                end
                default:
                begin
                    st_upd.phase = PH_BAD;
                end
            endcase
        end

        // Once the magnitude has overflowed it stays frozen.
        if (take_digit && !st.too_big)
        begin
            if (acc_over)
            begin
                st_upd.too_big = 1'b1;
            end
            else
            begin
                mag_upd = acc_sum[VALUE_BITS-2:0];
            end
        end
    end

    always_comb
    begin
        emit     = !has_char || is_last;
        ok_now   = ((st_upd.phase == PH_ZERO) || (st_upd.phase == PH_DIGITS)) &&
                   !st_upd.too_big;
        mag_wide = {{(VALUE_W-VALUE_BITS+1){1'b0}}, mag_upd};
        parse_ok = ok_now;
        if (!ok_now)
        begin
            value = '0;
        end
        else if (st_upd.negative)
        begin
            value = $signed(VALUE_W'(0) - mag_wide);
        end
        else
        begin
            value = $signed(mag_wide);
        end

        if (emit)
        begin
            st_next  = PARSE_STATE_RESET;
            mag_next = '0;
        end
        else
        begin
            st_next  = st_upd;
            mag_next = mag_upd;
        end
    end

endmodule

FILE: rtl/signed_dec_hex_int_parser.sv
// Signed decimal / hexadecimal integer text parser.
//
// Input channel: one character per beat (char_code, has_char, is_last) on
// in_valid / in_ready. A text may start with '-' or '+', then an optional
// 0x or 0X prefix, then at least one digit of the base. The beat with
// is_last set, or a beat with has_char low, ends the text.
// Output channel: one beat per text on out_valid / out_ready, giving
// parse_ok and the signed 64-bit value (zero when the text is rejected).
//
// The ending beat sits in the input register while the character step works
// on it; out_valid rises when the result register loads, once it is free.
// Throughput is one character per cycle unless an ending beat waits on a
// full result register. Longest path: multiply-by-base add, range compare.
// Reset empties both registers and returns the parser to the start of a
// text. When the receiver stalls, the result is held and in_ready stays
// high until a second ending beat would need the result register, so
// characters that end no text keep flowing.
module signed_dec_hex_int_parser
    import sdhp_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic        [CHAR_W-1:0]   char_code,
    input  logic                       has_char,
    input  logic                       is_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       parse_ok,
    output logic signed [VALUE_W-1:0]  value
);

    logic                      in_valid_reg;
    logic [CHAR_W-1:0]         char_reg;
    logic                      has_char_reg;
    logic                      is_last_reg;

    parse_state_t              st_reg;
    parse_state_t              st_next;
    logic [VALUE_BITS-2:0]     mag_reg;
    logic [VALUE_BITS-2:0]     mag_next;

    logic                      out_valid_reg;
    logic                      parse_ok_reg;
    logic signed [VALUE_W-1:0] value_reg;

    logic                      step_emit;
    logic                      step_ok;
    logic signed [VALUE_W-1:0] step_value;
    logic                      step_fire;
    logic                      out_free;

    sdhp_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .st        (st_reg),
        .mag       (mag_reg),
        .char_code (char_reg),
        .has_char  (has_char_reg),
        .is_last   (is_last_reg),
        .st_next   (st_next),
        .mag_next  (mag_next),
        .emit      (step_emit),
        .parse_ok  (step_ok),
        .value     (step_value)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign step_fire = in_valid_reg && (!step_emit || out_free);
    assign in_ready  = !in_valid_reg || step_fire;

    assign out_valid = out_valid_reg;
    assign parse_ok  = parse_ok_reg;
    assign value     = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            st_reg        <= PARSE_STATE_RESET;
            mag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step_fire)
            begin
                st_reg  <= st_next;
                mag_reg <= mag_next;
            end
            if (step_fire && step_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg     <= char_code;
            has_char_reg <= has_char;
            is_last_reg  <= is_last;
        end
        if (step_fire && step_emit)
        begin
            parse_ok_reg <= step_ok;
            value_reg    <= step_value;
        end
    end

endmodule
